@@ hw/rtl/multichannel_common_removal_defines.svh @@
// Assertion macros for the port checker of the common removal block.
`ifndef MULTICHANNEL_COMMON_REMOVAL_DEFINES_SVH
`define MULTICHANNEL_COMMON_REMOVAL_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define MCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MCR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/mcr_pkg.sv @@
// Shared types and constants of the multichannel common removal block.
package mcr_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_FORMAT = 1'd1;

    localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd2;
    localparam logic       FORMAT_16           = 1'b0;

    localparam logic signed [SAMPLE_W-1:0] CLAMP_HI16 = 24'sh007fff;
    localparam logic signed [SAMPLE_W-1:0] CLAMP_LO16 = -24'sh008000;
    localparam logic signed [SAMPLE_W-1:0] CLAMP_HI24 = 24'sh7fffff;
    localparam logic signed [SAMPLE_W-1:0] CLAMP_LO24 = -24'sh800000;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_stat;

endpackage

@@ hw/rtl/mcr_store.sv @@
// Frame store: one write port and one registered read port.
module mcr_store import mcr_pkg::*; #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [SAMPLE_W-1:0] i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [SAMPLE_W-1:0] o_rd_data
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/mcr_div.sv @@
// Serial divider giving the floor quotient of the frame sum by the channel count.
module mcr_div import mcr_pkg::*; #(
    parameter int SUM_W = 27,
    parameter int N_W   = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [N_W-1:0]          i_divisor,
    output logic signed [SUM_W-1:0] o_quotient,
    output t_div_stat               o_stat
);

    localparam int CW = $clog2(SUM_W + 1);

    logic                    r_busy;
    logic                    r_fix;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic                    r_neg;
    logic [SUM_W-1:0]        r_quo;
    logic [N_W-1:0]          r_rem;
    logic [N_W-1:0]          r_div;
    logic signed [SUM_W-1:0] r_q;
    logic                    r_rem_nz;

    logic [N_W:0] shifted;
    logic [N_W:0] diff;
    logic         ge;
    logic         nz;

    assign shifted = {r_rem, r_quo[SUM_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign ge      = !diff[N_W];
    assign nz      = (r_rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fix  <= 1'b0;
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= i_dividend[SUM_W-1] ? -i_dividend : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= CW'(SUM_W);
        end else if (r_busy) begin
            r_rem <= ge ? diff[N_W-1:0] : shifted[N_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_cnt <= r_cnt - CW'(1);
        end else if (r_fix) begin
            r_q      <= r_neg ? (-r_quo - SUM_W'(nz)) : r_quo;
            r_rem_nz <= nz;
        end
    end

    assign o_quotient    = r_q;
    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = r_rem_nz;

endmodule

@@ hw/rtl/multichannel_common_removal.sv @@
// The first result of a frame follows its last sample once the one-bit-per-cycle divider
// has formed the mean; each later result is read from the frame store and then written
// to the output register, which holds it while the receiver stalls.
// Input is taken one word a cycle while the block is between frames and a sample is offered.
// Synchronous active-low reset clears the control state, the frame sum and the
// registers (channel_count = 2, 16-bit format); the frame store needs no clearing.
module multichannel_common_removal import mcr_pkg::*; #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [23:0] sample_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SAMPLE_W-1:0]   m_axis_tdata,   // [23:0] sample_out
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(MAX_CHANNELS);
    localparam int N_W   = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W = SAMPLE_W + AW;
    localparam int RW    = SUM_W + 1;

    localparam logic signed [RW-1:0] HI16 = RW'(CLAMP_HI16);
    localparam logic signed [RW-1:0] LO16 = RW'(CLAMP_LO16);
    localparam logic signed [RW-1:0] HI24 = RW'(CLAMP_HI24);
    localparam logic signed [RW-1:0] LO24 = RW'(CLAMP_LO24);

    typedef enum logic [1:0] {S_IN, S_DIV, S_RD, S_OUT} t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_idx;
    logic [AW-1:0]           r_k;
    logic [AW-1:0]           r_last;
    logic signed [SUM_W-1:0] r_sum;
    logic [3:0]              r_channel_count;
    logic                    r_sample_format;
    logic                    r_out_valid;
    logic [SAMPLE_W-1:0]     r_out_data;
    logic                    r_out_last;

    logic                    in_acc;
    logic                    frame_end;
    logic                    out_free;
    logic [N_W-1:0]          n_eff;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] quotient;
    t_div_stat               div_stat;
    logic [SAMPLE_W-1:0]     rd_data;
    logic signed [RW-1:0]    diff;
    logic signed [RW-1:0]    res;
    logic signed [RW-1:0]    hi;
    logic signed [RW-1:0]    lo;
    logic [SAMPLE_W-1:0]     clamped;

    assign s_axis_tready = (r_state == S_IN);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign n_sum         = r_sum + SUM_W'(signed'(s_axis_tdata));

    always_comb begin
        if (32'(r_channel_count) > MAX_CHANNELS) begin
            n_eff = N_W'(MAX_CHANNELS);
        end else if (r_channel_count < 4'd2) begin
            n_eff = N_W'(2);
        end else begin
            n_eff = N_W'(r_channel_count);
        end
    end

    assign frame_end = (32'(r_idx) + 1) >= 32'(n_eff);

    always_comb begin
        diff = RW'(signed'(rd_data)) - RW'(quotient);
        res  = diff - RW'(div_stat.rem_nz && (diff > 0));
        hi   = (r_sample_format == FORMAT_16) ? HI16 : HI24;
        lo   = (r_sample_format == FORMAT_16) ? LO16 : LO24;
        if (res > hi) begin
            clamped = hi[SAMPLE_W-1:0];
        end else if (res < lo) begin
            clamped = lo[SAMPLE_W-1:0];
        end else begin
            clamped = res[SAMPLE_W-1:0];
        end
    end

    mcr_store #(
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_idx),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (r_state == S_RD),
        .i_rd_addr (r_k),
        .o_rd_data (rd_data)
    );

    mcr_div #(
        .SUM_W (SUM_W),
        .N_W   (N_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc && frame_end),
        .i_dividend (n_sum),
        .i_divisor  (n_eff),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHANNEL_COUNT_RESET;
            r_sample_format <= FORMAT_16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data;
                REG_SAMPLE_FORMAT: r_sample_format <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_idx       <= '0;
            r_k         <= '0;
            r_last      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IN: begin
                    if (in_acc) begin
                        if (frame_end) begin
                            r_last  <= r_idx;
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_k     <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                            r_sum <= n_sum;
                        end
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= clamped;
                        r_out_last  <= (r_k == r_last);
                        if (r_k == r_last) begin
                            r_state <= S_IN;
                        end else begin
                            r_k     <= r_k + AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ hw/rtl/mcr_checker.sv @@
// Port-level assertions for the common removal block and their bind.
`include "multichannel_common_removal_defines.svh"

module mcr_port_checker import mcr_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [SAMPLE_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    // A stalled output word keeps its contents.
    `MCR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

    // Reset empties the output register.
    `MCR_ASSERT_RST(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // While a frame is still being emitted, no new sample is taken.
    `MCR_ASSERT(a_emit_blocks_in, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input ready during frame emission")

endmodule

bind multichannel_common_removal mcr_port_checker u_mcr_checker (.*);

@@ dv/mcr_checker.sv @@
// Checker for the common removal block: predicts each frame's output words and compares them.
`timescale 1ns / 1ps
module mcr_checker import mcr_pkg::*; #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [SAMPLE_W-1:0]   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [SAMPLE_W-1:0]   i_out_data,
    input  logic                  i_out_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_compared
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } t_removal_word;

    t_removal_word              expected_outputs[$];
    logic signed [SAMPLE_W-1:0] frame_mem [MAX_CHANNELS];
    longint                     frame_sum = 0;
    int                         next_slot = 0;
    logic [3:0]                 reg_count = CHANNEL_COUNT_RESET;
    logic                       reg_fmt = FORMAT_16;
    int                         n_bad = 0;
    int                         n_compared = 0;

    assign o_fail_count = n_bad + o_pending;

    task automatic note_mismatch(input string what);
        if (n_bad < 10) begin
            $display("Mismatch at %0t: %s", $realtime, what);
        end
        n_bad++;
    endtask

    // Stores one sample; on the frame's last channel, queues one word per stored channel.
    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] smp);
        int            n;
        int            slot;
        longint        v;
        longint        hi;
        longint        lo;
        t_removal_word w;
        if (reg_count < 2) begin
            n = 2;
        end else if (reg_count > MAX_CHANNELS) begin
            n = MAX_CHANNELS;
        end else begin
            n = int'(reg_count);
        end
        slot = (next_slot >= MAX_CHANNELS) ? MAX_CHANNELS - 1 : next_slot;
        frame_mem[slot] = smp;
        frame_sum += longint'(smp);
        if (slot + 1 < n) begin
            next_slot = slot + 1;
            return;
        end
        if (reg_fmt == FORMAT_16) begin
            hi = longint'(CLAMP_HI16);
            lo = longint'(CLAMP_LO16);
        end else begin
            hi = longint'(CLAMP_HI24);
            lo = longint'(CLAMP_LO24);
        end
        for (int k = 0; k <= slot; k++) begin
            v = (longint'(frame_mem[k]) * n - frame_sum) / n;
            if (v > hi) begin
                v = hi;
            end else if (v < lo) begin
                v = lo;
            end
            w.value = v[SAMPLE_W-1:0];
            w.last = (k == slot);
            expected_outputs.push_back(w);
        end
        frame_sum = 0;
        next_slot = 0;
    endtask

    task automatic compare_word(input logic [SAMPLE_W-1:0] got_value, input logic got_last);
        t_removal_word want;
        if (expected_outputs.size() == 0) begin
            note_mismatch($sformatf("output word %h (last %b) with no frame pending",
                                    got_value, got_last));
            return;
        end
        want = expected_outputs.pop_front();
        if (got_value !== want.value) begin
            note_mismatch($sformatf("sample_out expected %h, got %h", want.value, got_value));
        end
        if (got_last !== want.last) begin
            note_mismatch($sformatf("tlast expected %b, got %b (sample_out %h)",
                                    want.last, got_last, want.value));
        end
        n_compared++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_outputs.delete();
            frame_sum = 0;
            next_slot = 0;
            reg_count = CHANNEL_COUNT_RESET;
            reg_fmt = FORMAT_16;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_CHANNEL_COUNT) begin
                    reg_count = i_cfg_data[3:0];
                end else if (i_cfg_addr == REG_SAMPLE_FORMAT) begin
                    reg_fmt = i_cfg_data[0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                compare_word(i_out_data, i_out_last);
            end
            if (i_in_valid && i_in_ready) begin
                absorb_sample(i_in_data);
            end
        end
        o_pending <= expected_outputs.size();
        o_compared <= n_compared;
    end

endmodule

@@ dv/tb_multichannel_common_removal.sv @@
// Testbench top for the common removal block: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module tb_multichannel_common_removal;
    import mcr_pkg::*;

    localparam int MAX_CHANNELS = 8;
    localparam int RANDOM_WORDS = 450;
    localparam int CALM_WORDS   = 60;
    localparam int SETTLE       = 64;
    localparam int CYCLE_LIMIT  = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = REG_CHANNEL_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int compared;
    int cycle_count = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold = 0;
    int words_sent = 0;
    int settings_used = 1;

    always #5 i_clk = ~i_clk;

    multichannel_common_removal #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    mcr_checker #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_last  (m_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_compared  (compared)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d output words outstanding.",
                     cycle_count, pending);
            $display("[multichannel_common_removal] ERROR");
            $finish;
        end
    end

    // The receiver stalls in bursts; a zero stall rate keeps tready high.
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            rx_hold <= $urandom_range(1, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [15:0] low16;
        low16 = 16'($urandom);
        case ($urandom_range(0, 9))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'h000000;
            3, 4: return {{8{low16[15]}}, low16};
            5: return 24'h007fff + 24'($urandom_range(0, 2));
            6: return 24'hff7fff + 24'($urandom_range(0, 2));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    // Stops sending, waits for every predicted word, then lets the block settle.
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [3:0] count, input logic fmt);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_CHANNEL_COUNT;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_addr <= REG_SAMPLE_FORMAT;
        i_cfg_data <= {3'b000, fmt};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int count_plan[15] = '{2, 8, 0, 15, 5, 1, 9, 3, 7, 4, 6, 8, 2, 12, 8};
        int random_sent;
        int phase;
        int len;
        random_sent = 0;
        phase = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: two channels, 16-bit clamp applied to full-scale 24-bit input.
        send_sample(24'h7fffff);
        send_sample(24'h800000);
        send_sample(24'h000000);
        send_sample(24'h000000);
        send_sample(24'h000001);
        send_sample(24'hfffffe);
        drain_and_settle();

        program_regs(4'd8, 1'b1);
        for (int i = 0; i < 8; i++) begin
            send_sample(i[0] ? 24'h800000 : 24'h7fffff);
        end
        drain_and_settle();

        // Odd divisor with negative quotients exercises truncation toward zero.
        program_regs(4'd3, 1'b1);
        send_sample(24'h000005);
        send_sample(24'hfffff9);
        send_sample(24'h000001);
        drain_and_settle();

        // A frame cut short when the channel count drops below the stored depth.
        program_regs(4'd8, FORMAT_16);
        for (int i = 0; i < 5; i++) begin
            send_sample(pick_sample());
        end
        drain_and_settle();
        program_regs(4'd4, FORMAT_16);
        send_sample(pick_sample());
        drain_and_settle();

        while (random_sent < RANDOM_WORDS) begin
            len = $urandom_range(20, 50);
            if (RANDOM_WORDS - random_sent <= CALM_WORDS) begin
                len = RANDOM_WORDS - random_sent;
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                    1: begin tx_gap_pct = 20; rx_stall_pct = 5;  end
                    default: begin tx_gap_pct = 40; rx_stall_pct = 15; end
                endcase
            end
            program_regs(4'(count_plan[phase % 15]), phase[0]);
            for (int i = 0; i < len; i++) begin
                send_sample(pick_sample());
            end
            random_sent += len;
            drain_and_settle();
            phase++;
        end

        $display("Sent %0d samples under %0d register settings, covering clamped and",
                 words_sent, settings_used);
        $display("out-of-range channel counts, both formats and cut-short frames; %0d words.",
                 compared);
        if (fail_count == 0) begin
            $display("[multichannel_common_removal] OK");
        end else begin
            $display("[multichannel_common_removal] ERROR");
        end
        $finish;
    end

endmodule

@@ multichannel_common_removal.f @@
+incdir+hw/rtl
hw/rtl/mcr_pkg.sv
hw/rtl/mcr_store.sv
hw/rtl/mcr_div.sv
hw/rtl/multichannel_common_removal.sv
hw/rtl/mcr_checker.sv
dv/mcr_checker.sv
dv/tb_multichannel_common_removal.sv
